// ----- rtl/fusc_pkg.sv -----
// ----------------------------------------------------------------------------
// fusc_pkg
// Shared types and constants of the firmware update session controller.
// ----------------------------------------------------------------------------
package fusc_pkg;

	localparam int PacketBytes = 16;
	localparam int SectorBytes = 4096;
	localparam int SectorShift = $clog2(SectorBytes);
	localparam int CountWidth  = $clog2(PacketBytes + 1);
	localparam int InitLength  = 12;
	localparam int SendLength  = 3 + PacketBytes;
	localparam int MaxSectors  = 511;

	localparam int CmdDepth = 2;
	localparam int RspDepth = 2;

	localparam logic [19:0] TimeoutReset  = 20'd30000;
	localparam logic [20:0] MaxSizeReset  = 21'd1048576;
	localparam logic [31:0] SlotAReset    = 32'h0020_0000;
	localparam logic [31:0] SlotBReset    = 32'h0030_0000;
	localparam logic [20:0] IdleMax       = 21'h1F_FFFF;

	typedef enum logic [1:0] {
		REG_TIMEOUT  = 2'd0,
		REG_MAX_SIZE = 2'd1,
		REG_SLOT_A   = 2'd2,
		REG_SLOT_B   = 2'd3
	} cfg_reg_t;

	typedef enum logic [2:0] {
		OP_INIT    = 3'd0,
		OP_SEND    = 3'd1,
		OP_FINISH  = 3'd2,
		OP_VERSION = 3'd3,
		OP_ABORT   = 3'd4,
		OP_TICK    = 3'd5,
		OP_UNKNOWN = 3'd6
	} cmd_op_t;

	typedef enum logic [2:0] {
		RSP_ACK     = 3'd0,
		RSP_NACK    = 3'd1,
		RSP_READY   = 3'd2,
		RSP_CSUM    = 3'd3,
		RSP_VERSION = 3'd4,
		RSP_ERROR   = 3'd5
	} rsp_code_t;

	typedef enum logic [2:0] {
		ERR_NONE       = 3'd0,
		ERR_BAD_LENGTH = 3'd1,
		ERR_BUSY       = 3'd2,
		ERR_BAD_SIZE   = 3'd3,
		ERR_BAD_ADDR   = 3'd4
	} err_t;

	typedef enum logic [1:0] {
		FLASH_NONE  = 2'd0,
		FLASH_ERASE = 2'd1,
		FLASH_WRITE = 2'd2
	} flash_op_t;

	typedef struct packed {
		logic [19:0] idle_limit;
		logic [20:0] max_image_size;
		logic [31:0] slot_a_address;
		logic [31:0] slot_b_address;
	} cfg_t;

	// classified command as it travels from front to back
	typedef struct packed {
		cmd_op_t       op;
		logic          len_ok;
		logic          csum_ok;
		logic [31:0]   version;
		logic [31:0]   address;
		logic [31:0]   size;
		logic [8:0]    sectors;
		logic [15:0]   seq;
		logic [127:0]  data;
	} cmd_t;

	typedef struct packed {
		rsp_code_t    response;
		err_t         error_detail;
		flash_op_t    flash_op;
		logic [31:0]  flash_address;
		logic [8:0]   flash_length;
		logic [63:0]  write_data_low;
		logic [63:0]  write_data_high;
		logic [31:0]  active_version;
		logic [31:0]  fallback_version;
		logic [31:0]  active_address;
		logic [31:0]  fallback_address;
	} rsp_t;

	typedef struct packed {
		logic busy;
	} status_t;

endpackage

// ----- rtl/fusc_fifo.sv -----
// ----------------------------------------------------------------------------
// fusc_fifo
// Small register queue with first-word fall-through read.
// ----------------------------------------------------------------------------
module fusc_fifo
	import fusc_pkg::*;
#(
	parameter int Width = 8,
	parameter int Depth = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [Width-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [Width-1:0] rdata,
	output logic             empty
);

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	logic [Width-1:0] mem_q [Depth];
	logic [PtrW-1:0]  wr_ptr_q;
	logic [PtrW-1:0]  rd_ptr_q;
	logic [CntW-1:0]  count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CntW'(Depth));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/fusc_front.sv -----
// ----------------------------------------------------------------------------
// fusc_front
// Decodes a host command and precomputes everything that needs no session
// state: length checks, packet XOR check and the erase sector count.
// ----------------------------------------------------------------------------
module fusc_front
	import fusc_pkg::*;
(
	input  logic [2:0]  mode,
	input  logic [7:0]  payload_length,
	input  logic [31:0] image_version,
	input  logic [31:0] dest_address,
	input  logic [31:0] image_size,
	input  logic [15:0] packet_number,
	input  logic [7:0]  packet_check,
	input  logic [63:0] packet_data_low,
	input  logic [63:0] packet_data_high,
	output cmd_t        cmd
);

	cmd_op_t      op;
	logic [127:0] data;
	logic [7:0]   xsum;
	logic [32:0]  rounded;
	logic [32:0]  sectors_full;

	always_comb begin
		unique case (mode)
			OP_INIT:    op = OP_INIT;
			OP_SEND:    op = OP_SEND;
			OP_FINISH:  op = OP_FINISH;
			OP_VERSION: op = OP_VERSION;
			OP_ABORT:   op = OP_ABORT;
			OP_TICK:    op = OP_TICK;
			default:    op = OP_UNKNOWN;
		endcase
	end

	assign data = {packet_data_high, packet_data_low};

	always_comb begin
		xsum = '0;
		for (int i = 0; i < PacketBytes; i++) begin
			xsum = xsum ^ data[8*i +: 8];
		end
	end

	// ceil(size / sector), held at the largest count the port can carry
	assign rounded      = {1'b0, image_size} + 33'(SectorBytes - 1);
	assign sectors_full = rounded >> SectorShift;

	always_comb begin
		cmd         = '0;
		cmd.op      = op;
		cmd.len_ok  = (op == OP_SEND) ? (payload_length == 8'(SendLength))
		                              : (payload_length == 8'(InitLength));
		cmd.csum_ok = (xsum == packet_check);
		cmd.version = image_version;
		cmd.address = dest_address;
		cmd.size    = image_size;
		cmd.sectors = (sectors_full > 33'(MaxSectors)) ? 9'(MaxSectors) : sectors_full[8:0];
		cmd.seq     = packet_number;
		cmd.data    = data;
	end

endmodule

// ----- rtl/fusc_back.sv -----
// ----------------------------------------------------------------------------
// fusc_back
// Holds the update session and image records and carries out one command
// per cycle while the result queue has room, producing at most one response.
// ----------------------------------------------------------------------------
module fusc_back
	import fusc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  cmd_t    cmd,
	input  logic    cmd_valid,
	output logic    cmd_pop,
	input  logic    rsp_room,
	output logic    rsp_push,
	output rsp_t    rsp,
	output status_t status
);

	logic        busy_q,            busy_d;
	logic [31:0] pending_version_q, pending_version_d;
	logic [31:0] slot_address_q,    slot_address_d;
	logic [20:0] total_size_q,      total_size_d;
	logic [20:0] received_count_q,  received_count_d;
	logic [15:0] next_sequence_q,   next_sequence_d;
	logic [20:0] idle_count_q,      idle_count_d;
	logic [31:0] live_version_q,    live_version_d;
	logic [31:0] spare_version_q,   spare_version_d;
	logic [31:0] live_address_q,    live_address_d;
	logic [31:0] spare_address_q,   spare_address_d;

	logic                  fire;
	logic                  has_rsp;
	logic [20:0]           idle_inc;
	logic [20:0]           remain;
	logic [CountWidth-1:0] count;
	logic [127:0]          kept;

	assign fire    = cmd_valid && rsp_room;
	assign cmd_pop = fire;
	assign rsp_push = fire && has_rsp;
	assign status.busy = busy_q;

	assign idle_inc = (idle_count_q == IdleMax) ? idle_count_q : idle_count_q + 1'b1;
	assign remain   = (total_size_q >= received_count_q) ? total_size_q - received_count_q
	                                                     : '0;
	assign count    = (remain < 21'(PacketBytes)) ? CountWidth'(remain)
	                                              : CountWidth'(PacketBytes);

	// drop data bytes past the clipped count
	always_comb begin
		kept = '0;
		for (int i = 0; i < PacketBytes; i++) begin
			if (CountWidth'(i) < count) begin
				kept[8*i +: 8] = cmd.data[8*i +: 8];
			end
		end
	end

	always_comb begin
		busy_d            = busy_q;
		pending_version_d = pending_version_q;
		slot_address_d    = slot_address_q;
		total_size_d      = total_size_q;
		received_count_d  = received_count_q;
		next_sequence_d   = next_sequence_q;
		idle_count_d      = '0;
		live_version_d    = live_version_q;
		spare_version_d   = spare_version_q;
		live_address_d    = live_address_q;
		spare_address_d   = spare_address_q;
		has_rsp           = 1'b1;
		rsp               = '0;

		unique case (cmd.op)
			OP_TICK: begin
				has_rsp      = 1'b0;
				idle_count_d = idle_count_q;
				if (busy_q) begin
					idle_count_d = idle_inc;
					if (idle_inc > {1'b0, cfg.idle_limit}) begin
						busy_d       = 1'b0;
						has_rsp      = 1'b1;
						rsp.response = RSP_ACK;
					end
				end
			end
			OP_INIT: begin
				rsp.response = RSP_ERROR;
				if (!cmd.len_ok) begin
					rsp.error_detail = ERR_BAD_LENGTH;
				end else if (busy_q) begin
					rsp.error_detail = ERR_BUSY;
				end else if (cmd.size == '0 || cmd.size > {11'b0, cfg.max_image_size}) begin
					rsp.error_detail = ERR_BAD_SIZE;
				end else if (cmd.address != cfg.slot_a_address
				          && cmd.address != cfg.slot_b_address) begin
					rsp.error_detail = ERR_BAD_ADDR;
				end else begin
					busy_d            = 1'b1;
					pending_version_d = cmd.version;
					slot_address_d    = cmd.address;
					total_size_d      = cmd.size[20:0];
					received_count_d  = '0;
					next_sequence_d   = '0;
					rsp.response      = RSP_READY;
					rsp.flash_op      = FLASH_ERASE;
					rsp.flash_address = cmd.address;
					rsp.flash_length  = cmd.sectors;
				end
			end
			OP_SEND: begin
				if (!busy_q || !cmd.len_ok || cmd.seq != next_sequence_q) begin
					rsp.response = RSP_NACK;
				end else if (!cmd.csum_ok) begin
					rsp.response = RSP_CSUM;
				end else begin
					rsp.response = RSP_ACK;
					if (count != '0) begin
						rsp.flash_op        = FLASH_WRITE;
						rsp.flash_address   = slot_address_q + {11'b0, received_count_q};
						rsp.flash_length    = 9'(count);
						rsp.write_data_low  = kept[63:0];
						rsp.write_data_high = kept[127:64];
					end
					received_count_d = received_count_q + 21'(count);
					next_sequence_d  = next_sequence_q + 1'b1;
				end
			end
			OP_FINISH: begin
				if (!busy_q || received_count_q != total_size_q) begin
					rsp.response = RSP_NACK;
				end else begin
					spare_version_d = live_version_q;
					spare_address_d = live_address_q;
					live_version_d  = pending_version_q;
					live_address_d  = slot_address_q;
					busy_d          = 1'b0;
					rsp.response    = RSP_ACK;
				end
			end
			OP_VERSION: begin
				rsp.response         = RSP_VERSION;
				rsp.active_version   = live_version_q;
				rsp.fallback_version = spare_version_q;
				rsp.active_address   = live_address_q;
				rsp.fallback_address = spare_address_q;
			end
			OP_ABORT: begin
				if (busy_q) begin
					busy_d       = 1'b0;
					rsp.response = RSP_ACK;
				end else begin
					rsp.response = RSP_NACK;
				end
			end
			default: begin
				rsp.response = RSP_ERROR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q            <= 1'b0;
			pending_version_q <= '0;
			slot_address_q    <= '0;
			total_size_q      <= '0;
			received_count_q  <= '0;
			next_sequence_q   <= '0;
			idle_count_q      <= '0;
			live_version_q    <= '0;
			spare_version_q   <= '0;
			live_address_q    <= '0;
			spare_address_q   <= '0;
		end else if (fire) begin
			busy_q            <= busy_d;
			pending_version_q <= pending_version_d;
			slot_address_q    <= slot_address_d;
			total_size_q      <= total_size_d;
			received_count_q  <= received_count_d;
			next_sequence_q   <= next_sequence_d;
			idle_count_q      <= idle_count_d;
			live_version_q    <= live_version_d;
			spare_version_q   <= spare_version_d;
			live_address_q    <= live_address_d;
			spare_address_q   <= spare_address_d;
		end
	end

endmodule

// ----- rtl/firmware_update_session_controller.sv -----
// ----------------------------------------------------------------------------
// firmware_update_session_controller
// Runs one firmware update session from decoded host commands and ticks.
//
// Commands enter through a queue-style port: present the decoded fields and
// raise push; the transaction completes on an edge where full is low. A
// millisecond tick is a command of its own mode. Each command yields zero or
// one response, read from the result port: while empty is low the oldest
// response sits on the result fields, and pop takes it.
// A command is registered in the command queue, then carried out by the
// session unit, whose response is registered in the result queue and from
// there appears on the result fields. The block takes one command per cycle;
// the session unit updates its state as it takes each command, so back-to-back
// commands keep that rate as long as responses are popped.
// If the consumer stalls, responses collect in a two-entry result queue,
// then the session unit holds and the two-entry command queue fills, after
// which full rises. Nothing is dropped.
// Reset clears both queues, the session and the image records and loads the
// register defaults. Registers sit on the APB port at 4-byte strides; the user
// writes them only while no command is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module firmware_update_session_controller
	import fusc_pkg::*;
#(
	parameter int CMD_DEPTH = CmdDepth,
	parameter int RSP_DEPTH = RspDepth
) (
	input  logic        clk,
	input  logic        arst_n,
	// command channel
	input  logic        push,
	output logic        full,
	input  logic [2:0]  mode,
	input  logic [7:0]  payload_length,
	input  logic [31:0] image_version,
	input  logic [31:0] dest_address,
	input  logic [31:0] image_size,
	input  logic [15:0] packet_number,
	input  logic [7:0]  packet_check,
	input  logic [63:0] packet_data_low,
	input  logic [63:0] packet_data_high,
	// response channel
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  response,
	output logic [2:0]  error_detail,
	output logic [1:0]  flash_op,
	output logic [31:0] flash_address,
	output logic [8:0]  flash_length,
	output logic [63:0] write_data_low,
	output logic [63:0] write_data_high,
	output logic [31:0] active_version,
	output logic [31:0] fallback_version,
	output logic [31:0] active_address,
	output logic [31:0] fallback_address,
	// register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int CmdW = $bits(cmd_t);
	localparam int RspW = $bits(rsp_t);

	cfg_t        cfg_q;
	cfg_reg_t    reg_sel;
	logic        reg_write;

	cmd_t        front_cmd;
	logic [CmdW-1:0] cmd_rdata;
	logic        cmd_empty;
	logic        cmd_pop;

	rsp_t        back_rsp;
	logic        rsp_push;
	logic        rsp_full;
	logic [RspW-1:0] rsp_rdata;
	rsp_t        out_rsp;
	status_t     status;

	// register port: zero-wait, write on the access phase
	assign pready    = 1'b1;
	assign reg_sel   = cfg_reg_t'(paddr[3:2]);
	assign reg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.idle_limit     <= TimeoutReset;
			cfg_q.max_image_size <= MaxSizeReset;
			cfg_q.slot_a_address <= SlotAReset;
			cfg_q.slot_b_address <= SlotBReset;
		end else if (reg_write) begin
			unique case (reg_sel)
				REG_TIMEOUT:  cfg_q.idle_limit     <= pwdata[19:0];
				REG_MAX_SIZE: cfg_q.max_image_size <= pwdata[20:0];
				REG_SLOT_A:   cfg_q.slot_a_address <= pwdata;
				REG_SLOT_B:   cfg_q.slot_b_address <= pwdata;
				default:      cfg_q.slot_b_address <= cfg_q.slot_b_address;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_TIMEOUT:  prdata = {12'b0, cfg_q.idle_limit};
			REG_MAX_SIZE: prdata = {11'b0, cfg_q.max_image_size};
			REG_SLOT_A:   prdata = cfg_q.slot_a_address;
			REG_SLOT_B:   prdata = cfg_q.slot_b_address;
			default:      prdata = '0;
		endcase
	end

	// front: classify the incoming transaction
	fusc_front u_front (
		.mode             (mode),
		.payload_length   (payload_length),
		.image_version    (image_version),
		.dest_address     (dest_address),
		.image_size       (image_size),
		.packet_number    (packet_number),
		.packet_check     (packet_check),
		.packet_data_low  (packet_data_low),
		.packet_data_high (packet_data_high),
		.cmd              (front_cmd)
	);

	// command queue decouples host pushes from the session unit
	fusc_fifo #(
		.Width (CmdW),
		.Depth (CMD_DEPTH)
	) u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (front_cmd),
		.full   (full),
		.pop    (cmd_pop),
		.rdata  (cmd_rdata),
		.empty  (cmd_empty)
	);

	// back: advance the session only when the result queue has room
	fusc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd       (cmd_t'(cmd_rdata)),
		.cmd_valid (!cmd_empty),
		.cmd_pop   (cmd_pop),
		.rsp_room  (!rsp_full),
		.rsp_push  (rsp_push),
		.rsp       (back_rsp),
		.status    (status)
	);

	// result queue: hold responses while the consumer stalls
	fusc_fifo #(
		.Width (RspW),
		.Depth (RSP_DEPTH)
	) u_rsp_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (rsp_push),
		.wdata  (back_rsp),
		.full   (rsp_full),
		.pop    (pop),
		.rdata  (rsp_rdata),
		.empty  (empty)
	);

	assign out_rsp          = rsp_t'(rsp_rdata);
	assign response         = out_rsp.response;
	assign error_detail     = out_rsp.error_detail;
	assign flash_op         = out_rsp.flash_op;
	assign flash_address    = out_rsp.flash_address;
	assign flash_length     = out_rsp.flash_length;
	assign write_data_low   = out_rsp.write_data_low;
	assign write_data_high  = out_rsp.write_data_high;
	assign active_version   = out_rsp.active_version;
	assign fallback_version = out_rsp.fallback_version;
	assign active_address   = out_rsp.active_address;
	assign fallback_address = out_rsp.fallback_address;

`ifndef SYNTHESIS
	// a session only opens with a ready response
	a_open_with_ready: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(status.busy) |-> $past(rsp_push && back_rsp.response == RSP_READY))
		else $error("session opened without a ready response");

	// a session only closes with a response (finish, abort or timeout)
	a_close_with_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(status.busy) |-> $past(rsp_push && back_rsp.response == RSP_ACK))
		else $error("session closed without an ack response");

	// the session unit never advances into a full result queue
	a_no_rsp_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> !rsp_full)
		else $error("command executed while result queue full");
`endif

endmodule
